[sv/alist_pkg.sv]
// alist_pkg: shared constants, operation codes and the control/status
// bundles that join the list controller and the list datapath.
// No dependencies.
package alist_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_BITS  = FUNC_W + VAL_W + POS_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + STAT_W + CNT_W + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_LIN_FIND = 3'd0,
    FN_BIN_FIND = 3'd1,
    FN_REM_VAL  = 3'd2,
    FN_REM_IDX  = 3'd3,
    FN_APPEND   = 3'd4
  } func_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;       // capture the accepted request
    logic init;       // set up pointers / do append for the captured request
    logic scan;       // one step of the linear walk
    logic bin_issue;  // read the middle entry of the search window
    logic bin_cmp;    // compare the middle entry; flag a hit or shrink the window
    logic finish;     // load the result register
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  pos_bad;
    logic  scan_done;
    logic  bin_live;
    logic  bin_hit;
    logic  out_free;
  } sts_t;

endpackage

[sv/array_list_engine.sv]
// array_list_engine: top level of the list engine; unpacks the request
// stream, joins alist_ctrl and alist_dp, packs the result stream.
// Depends on alist_pkg, alist_ctrl, alist_dp.
//
//  Channel   Direction  Ports                               Payload
//  request   in         in_tvalid/in_tready/in_tdata[47:0]  func, value, position
//  result    out        out_tvalid/out_tready/out_tdata[23:0]
//                                                           found, status,
//                                                           removed_count, list_length
//
// Sequence: one request at a time. Linear find, remove by value and remove
//   by index walk entries through the single memory read port, one per
//   cycle. Remove by index walks only the entries above the position; linear
//   find stops at the first match. Binary find runs each halving step as a
//   read of the middle entry (S_BIN_RD) then a compare (S_BIN_CMP); append
//   and unknown operations go straight from dispatch to the result load.
// Reset: rst_n low clears the length to zero and drops any pending result;
//   stored entries are not cleared, only entries below the length are read.
// Stalls: a new request is taken while the previous result still waits in
//   the output register; the engine holds its finished result only while that
//   register is occupied and out_tready is low.
module array_list_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [2:0] func, [34:3] value, [40:35] position, [47:41] zero
  input  logic [alist_pkg::IN_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] found, [2:1] status, [9:3] removed_count, [16:10] list_length,
  // [23:17] zero
  output logic [alist_pkg::OUT_W-1:0] out_tdata
);
  import alist_pkg::*;

  cmd_t                    cmd;
  sts_t                    sts;
  func_t                   req_func;
  logic signed [VAL_W-1:0] req_value;
  logic [POS_W-1:0]        req_pos;
  logic                    res_found;
  logic [STAT_W-1:0]       res_status;
  logic [CNT_W-1:0]        res_removed;
  logic [CNT_W-1:0]        res_length;

  // Unpack the request; unknown function codes pass through and do nothing
  assign req_func  = func_t'(in_tdata[FUNC_W-1:0]);
  assign req_value = in_tdata[FUNC_W +: VAL_W];
  assign req_pos   = in_tdata[FUNC_W + VAL_W +: POS_W];

  alist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  alist_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_func    (req_func),
    .req_value   (req_value),
    .req_pos     (req_pos),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .res_found   (res_found),
    .res_status  (res_status),
    .res_removed (res_removed),
    .res_length  (res_length)
  );

  // Pack the result, padding to whole bytes
  assign out_tdata = {{(OUT_W - OUT_BITS){1'b0}},
                      res_length, res_removed, res_status, res_found};

endmodule

[sv/alist_ctrl.sv]
// alist_ctrl: sequencer for the list engine; steps the datapath through
// dispatch, linear walk, halving search and result hand-off.
// Depends on alist_pkg.
module alist_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  alist_pkg::sts_t   sts,
  output alist_pkg::cmd_t   cmd
);
  import alist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_BIN_RD,
    S_BIN_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.init = 1'b1;
        case (sts.func)
          FN_LIN_FIND, FN_REM_VAL: state_nxt = S_SCAN;
          FN_REM_IDX:              state_nxt = sts.pos_bad ? S_FIN : S_SCAN;
          FN_BIN_FIND:             state_nxt = S_BIN_RD;
          default:                 state_nxt = S_FIN;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_BIN_RD: begin
        if (sts.bin_live) begin
          cmd.bin_issue = 1'b1;
          state_nxt     = S_BIN_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_BIN_CMP: begin
        cmd.bin_cmp = 1'b1;
        state_nxt   = sts.bin_hit ? S_FIN : S_BIN_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/alist_dp.sv]
// alist_dp: list storage, length, walk pointers, search window and the
// result register of the list engine.
// Depends on alist_pkg; driven by alist_ctrl through cmd_t / sts_t.
module alist_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  alist_pkg::func_t                     req_func,
  input  logic signed [alist_pkg::VAL_W-1:0]   req_value,
  input  logic        [alist_pkg::POS_W-1:0]   req_pos,
  input  alist_pkg::cmd_t                      cmd,
  output alist_pkg::sts_t                      sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic                                 res_found,
  output logic        [alist_pkg::STAT_W-1:0]  res_status,
  output logic        [alist_pkg::CNT_W-1:0]   res_removed,
  output logic        [alist_pkg::CNT_W-1:0]   res_length
);
  import alist_pkg::*;

  logic signed [VAL_W-1:0] mem [CAPACITY];

  func_t                   func_r;
  logic signed [VAL_W-1:0] value_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        n_r;
  logic [CNT_W-1:0]        rp_r;
  logic [CNT_W-1:0]        wp_r;
  logic [CNT_W-1:0]        lo_r;
  logic [CNT_W-1:0]        hi_r;      // exclusive upper bound of window
  logic                    dv_r;      // rdata_r holds a walk entry
  logic                    hit_r;
  logic                    comp_r;    // walk compacts the list
  logic [STAT_W-1:0]       st_r;
  logic signed [VAL_W-1:0] rdata_r;

  logic                    out_valid_r;
  logic                    found_r;
  logic [STAT_W-1:0]       status_r;
  logic [CNT_W-1:0]        removed_r;
  logic [CNT_W-1:0]        length_r;

  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    scan_live;
  logic                    keep;
  logic                    eq;
  logic                    full;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic signed [VAL_W-1:0] wdata;
  logic [CNT_W-1:0]        removed;
  logic                    found;

  always_comb begin
    scan_live = (rp_r < n_r);
    mid_sum   = ({1'b0, lo_r} + {1'b0, hi_r}) - {{CNT_W{1'b0}}, 1'b1};
    mid       = mid_sum[CNT_W:1];
    rd_addr   = cmd.bin_issue ? mid[ADDR_W-1:0] : rp_r[ADDR_W-1:0];
    eq        = (rdata_r == value_r);
    keep      = (func_r == FN_REM_IDX) || !eq;
    full      = (n_r == CNT_W'(CAPACITY));
    removed   = comp_r ? (n_r - wp_r) : '0;

    we    = 1'b0;
    waddr = wp_r[ADDR_W-1:0];
    wdata = rdata_r;
    if (cmd.init && (func_r == FN_APPEND) && !full) begin
      we    = 1'b1;
      waddr = n_r[ADDR_W-1:0];
      wdata = value_r;
    end else if (cmd.scan && dv_r && comp_r && keep) begin
      we = 1'b1;
    end

    case (func_r)
      FN_LIN_FIND, FN_BIN_FIND: found = hit_r;
      FN_REM_VAL:               found = (removed != '0);
      default:                  found = 1'b0;
    endcase

    sts.func      = func_r;
    sts.pos_bad   = ({1'b0, pos_r} >= n_r);
    sts.scan_done = (!scan_live && !dv_r) || hit_r;
    sts.bin_live  = (lo_r < hi_r);
    sts.bin_hit   = eq;
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= req_func;
      value_r <= req_value;
      pos_r   <= req_pos;
      hit_r   <= 1'b0;
      comp_r  <= 1'b0;
      st_r    <= ST_OK;
      dv_r    <= 1'b0;
    end
    if (cmd.init) begin
      dv_r <= 1'b0;
      case (func_r)
        FN_LIN_FIND: begin
          rp_r <= '0;
          wp_r <= '0;
        end
        FN_REM_VAL: begin
          rp_r   <= '0;
          wp_r   <= '0;
          comp_r <= 1'b1;
        end
        FN_REM_IDX: begin
          if (sts.pos_bad) begin
            st_r <= ST_RANGE;
          end else begin
            rp_r   <= CNT_W'(pos_r) + CNT_W'(1);
            wp_r   <= CNT_W'(pos_r);
            comp_r <= 1'b1;
          end
        end
        FN_BIN_FIND: begin
          lo_r <= '0;
          hi_r <= n_r;
        end
        FN_APPEND: begin
          if (full) begin
            st_r <= ST_FULL;
          end
        end
        default: ;
      endcase
    end
    if (cmd.scan) begin
      dv_r <= scan_live;
      if (scan_live) begin
        rp_r <= rp_r + CNT_W'(1);
      end
      if (dv_r) begin
        if (comp_r && keep) begin
          wp_r <= wp_r + CNT_W'(1);
        end
        if (!comp_r && eq) begin
          hit_r <= 1'b1;
        end
      end
    end
    if (cmd.bin_cmp) begin
      if (eq) begin
        hit_r <= 1'b1;
      end else if (rdata_r < value_r) begin
        lo_r <= mid + CNT_W'(1);
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.finish) begin
      found_r   <= found;
      status_r  <= st_r;
      removed_r <= removed;
      length_r  <= comp_r ? wp_r : n_r;
    end
  end

  // Control state: list length and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init && (func_r == FN_APPEND) && !full) begin
        n_r <= n_r + CNT_W'(1);
      end
      if (cmd.finish && comp_r) begin
        n_r <= wp_r;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign res_found   = found_r;
  assign res_status  = status_r;
  assign res_removed = removed_r;
  assign res_length  = length_r;

endmodule

[bench/tb_array_list_engine.sv]
`timescale 1ns / 100ps
// tb_array_list_engine: self-checking bench for the list engine; a shadow list
// predicts every reply, random sender/receiver pacing exercises the streams.
// Depends on alist_pkg and array_list_engine.
module tb_array_list_engine;
  import alist_pkg::*;

  // Opcodes the engine must ignore
  localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  localparam int ITEM_TARGET  = 1300;
  localparam int HOLD_AT      = 600;   // requests sent before the long output hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT   = 4000;

  // Shadow copy of the list: predicts one reply per accepted request and
  // checks replies in order.
  class list_tracker;
    typedef struct {
      logic              found;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  removed;
      logic [CNT_W-1:0]  len;
    } reply_t;

    logic signed [VAL_W-1:0] entries [CAPACITY];
    int                      used;
    int                      errors;
    reply_t                  awaited[$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function logic scan_for(logic signed [VAL_W-1:0] v);
      for (int i = 0; i < used; i++)
        if (entries[i] == v) return 1'b1;
      return 1'b0;
    endfunction

    // Halving search as the engine runs it; misses are legal on unsorted data
    function logic halve_for(logic signed [VAL_W-1:0] v);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = used - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (entries[mid] == v) return 1'b1;
        if (entries[mid] < v) lo = mid + 1;
        else hi = mid - 1;
      end
      return 1'b0;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic signed [VAL_W-1:0] value,
                               logic [POS_W-1:0] pos);
      reply_t r;
      int     wr;
      r.found   = 1'b0;
      r.status  = ST_OK;
      r.removed = '0;
      case (func)
        FN_LIN_FIND: r.found = scan_for(value);
        FN_BIN_FIND: r.found = halve_for(value);
        FN_REM_VAL: begin
          // compact in place, dropping every match including adjacent repeats
          wr = 0;
          for (int rd = 0; rd < used; rd++)
            if (entries[rd] != value) begin
              entries[wr] = entries[rd];
              wr++;
            end
          r.removed = CNT_W'(used - wr);
          r.found   = (used != wr);
          used      = wr;
        end
        FN_REM_IDX: begin
          if (int'(pos) >= used) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = int'(pos); i + 1 < used; i++) entries[i] = entries[i + 1];
            used--;
            r.removed = CNT_W'(1);
          end
        end
        FN_APPEND: begin
          if (used >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            entries[used] = value;
            used++;
          end
        end
        default: ;
      endcase
      r.len   = CNT_W'(used);
      awaited = {awaited, r};
    endfunction

    task report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("[%0t] reply mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
      errors++;
    endtask

    task check_reply(input logic [OUT_W-1:0] word);
      reply_t want;
      if (awaited.size() == 0) begin
        report("unrequested reply", 32'(word), 32'd0);
        return;
      end
      want = awaited.pop_front();
      if (word[0] !== want.found) report("found", 32'(word[0]), 32'(want.found));
      if (word[2:1] !== want.status) report("status", 32'(word[2:1]), 32'(want.status));
      if (word[9:3] !== want.removed) report("removed_count", 32'(word[9:3]), 32'(want.removed));
      if (word[16:10] !== want.len) report("list_length", 32'(word[16:10]), 32'(want.len));
      if (word[OUT_W-1:17] !== '0) report("padding", 32'(word[OUT_W-1:17]), 32'd0);
    endtask
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  list_tracker      shadow     = new();
  int               sent_count = 0;   // every transfer on the request side
  int               sent_real  = 0;   // transfers with a defined opcode
  int               idle_cycles = 0;
  bit               send_burst = 1'b0;
  bit               recv_burst = 1'b0;
  bit               hold_done  = 1'b0;
  logic [VAL_W-1:0] value_pool [6];

  array_list_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb_array_list_engine failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request after a random gap; note it in the shadow list on the
  // edge where the transfer happens. Bursts run back to back with no gap.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [VAL_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    int              gap;
    logic [IN_W-1:0] word;
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    gap  = send_burst ? 0 : $urandom_range(0, 10);
    word = '0;
    word[FUNC_W-1:0]                            = func;
    word[FUNC_W +: VAL_W]                       = value;
    word[FUNC_W + VAL_W +: POS_W]               = pos;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.note_request(func, value, pos);
    sent_count++;
    if (func <= FN_APPEND) sent_real++;
  endtask

  // New small value set per phase so finds and removals hit repeats
  task automatic refresh_pool();
    value_pool[0] = $urandom;
    value_pool[1] = $urandom_range(0, 15);
    value_pool[2] = -$urandom_range(1, 15);
    value_pool[3] = $urandom;
    value_pool[4] = VAL_MIN;
    value_pool[5] = VAL_MAX;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return value_pool[r];
    if (r < 8 || shadow.used == 0) return $urandom;
    return shadow.entries[$urandom_range(0, shadow.used - 1)];
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (shadow.used > 0 && $urandom_range(0, 2) != 0)
      return POS_W'($urandom_range(0, shadow.used - 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Receiver: random stall before each reply, with runs of no stall, and one
  // long hold mid-run so the engine fills up and stops taking requests.
  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      shadow.check_reply(out_tdata);
    end
  end

  initial begin : stimulus
    int               n;
    int               base;
    logic [VAL_W-1:0] probe;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, ignored opcodes, extremes, repeats, range edges
    send_request(FN_LIN_FIND, 32'd0, 6'd0);
    send_request(FN_BIN_FIND, 32'd0, 6'd0);
    send_request(FN_REM_VAL, 32'd5, 6'd0);
    send_request(FN_REM_IDX, 32'd0, 6'd0);
    send_request(FN_SPARE_LO, VAL_MAX, 6'd63);
    send_request(FN_SPARE_MID, 32'd0, 6'd0);
    send_request(FN_SPARE_HI, VAL_MIN, 6'd63);
    send_request(FN_APPEND, VAL_MIN, 6'd0);
    send_request(FN_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_request(FN_APPEND, 32'd0, 6'd0);
    send_request(FN_APPEND, 32'd7, 6'd0);
    send_request(FN_APPEND, 32'd7, 6'd0);
    send_request(FN_APPEND, 32'd7, 6'd0);
    send_request(FN_APPEND, VAL_MAX, 6'd0);
    send_request(FN_LIN_FIND, 32'd7, 6'd0);
    send_request(FN_BIN_FIND, VAL_MAX, 6'd0);
    send_request(FN_BIN_FIND, 32'd1, 6'd0);
    send_request(FN_REM_VAL, 32'd7, 6'd0);     // three adjacent copies go at once
    send_request(FN_REM_IDX, 32'd0, 6'd63);    // past the end
    send_request(FN_REM_IDX, 32'd0, 6'd3);     // last entry
    send_request(FN_REM_IDX, 32'd0, 6'd0);
    send_request(FN_APPEND, -32'sd100, 6'd0);  // breaks the ordering
    send_request(FN_BIN_FIND, -32'sd100, 6'd0);
    send_request(FN_LIN_FIND, -32'sd100, 6'd0);

    // Random phases of well-formed work with random content, plus noise
    while (sent_real < ITEM_TARGET) begin
      refresh_pool();
      case ($urandom_range(0, 3))
        0: begin
          // fill, often to the full mark, then take the last slot back
          n = $urandom_range(4, 72);
          repeat (n) begin
            if ($urandom_range(0, 5) == 0)
              send_request($urandom_range(0, 1) ? FN_LIN_FIND : FN_BIN_FIND,
                           pick_value(), POS_W'($urandom));
            else
              send_request(FN_APPEND, pick_value(), POS_W'($urandom));
          end
          if (shadow.used > 0) send_request(FN_REM_IDX, pick_value(), POS_W'(shadow.used - 1));
          send_request(FN_REM_IDX, pick_value(), 6'd63);
        end
        1: begin
          // empty the list, rebuild it ascending, then run halving searches
          while (shadow.used > 0) begin
            if ($urandom_range(0, 1))
              send_request(FN_REM_VAL, shadow.entries[0], POS_W'($urandom));
            else
              send_request(FN_REM_IDX, pick_value(), POS_W'($urandom_range(0, shadow.used - 1)));
          end
          base = int'($urandom) >>> 2;
          n    = $urandom_range(1, 64);
          repeat (n) begin
            send_request(FN_APPEND, VAL_W'(base), POS_W'($urandom));
            if ($urandom_range(0, 3) != 0) base = base + $urandom_range(1, 500);
          end
          n = $urandom_range(6, 16);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: probe = shadow.entries[$urandom_range(0, shadow.used - 1)];
              1: probe = shadow.entries[$urandom_range(0, shadow.used - 1)] + 1;
              2: probe = shadow.entries[$urandom_range(0, shadow.used - 1)] - 1;
              default: probe = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            endcase
            send_request($urandom_range(0, 4) ? FN_BIN_FIND : FN_LIN_FIND, probe,
                         POS_W'($urandom));
          end
        end
        2: begin
          // removals by value and by position, some past the end
          n = $urandom_range(4, 16);
          repeat (n) begin
            if ($urandom_range(0, 1))
              send_request(FN_REM_VAL, pick_value(), POS_W'($urandom));
            else
              send_request(FN_REM_IDX, pick_value(), pick_pos());
          end
        end
        default: begin
          // noise: any opcode, any value, any position
          n = $urandom_range(4, 12);
          repeat (n) send_request(FUNC_W'($urandom_range(0, 7)), $urandom,
                                  POS_W'($urandom_range(0, 63)));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every reply, then watch for strays
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("tb_array_list_engine passed");
    end else begin
      $display("tb_array_list_engine failed");
    end
    $finish;
  end

endmodule
